>>> hw/rtl/osplit_pkg.sv
// Shared types and constants of the octree point splitter.
// Register map codes, fixed field widths and octant bit positions.
// No dependencies.
package osplit_pkg;

  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int REG_IDX_W  = 3;
  localparam int SIZE_W     = 31;
  localparam int INTERVAL_W = 40;
  localparam int NUM_OCT    = 8;
  localparam int OCT_W      = 3;

  localparam int OCT_X_BIT  = 2;
  localparam int OCT_Y_BIT  = 1;
  localparam int OCT_Z_BIT  = 0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTRE_X    = 3'd0,
    REG_CENTRE_Y    = 3'd1,
    REG_CENTRE_Z    = 3'd2,
    REG_NODE_SIZE   = 3'd3,
    REG_SAMP_PERIOD = 3'd4
  } reg_idx_t;

endpackage

>>> hw/rtl/octree_point_splitter.sv
// Results are registered: an accepted point's result enters the result register (skid if held).
// Throughput: one point per cycle while the skid register is empty; counter, phase and total
// update as the point is accepted, and the octant counter read-modify-write sets that rate.
// A two-entry output stage (result register plus skid register) keeps in_ready registered.
// Reset (rst, synchronous, active high) clears counters, phase, total, output valids and
// restores the configuration registers to their defaults (sampling period 1, others 0).
module octree_point_splitter
  import osplit_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // point input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          start_node,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OCT_W-1:0]              octant,
  output logic                          sampled,
  output logic [COUNT_WIDTH-1:0]        octant_count,
  output logic [COUNT_WIDTH-1:0]        sampled_total,
  output logic signed [COORD_WIDTH-1:0] child_centre_x,
  output logic signed [COORD_WIDTH-1:0] child_centre_y,
  output logic signed [COORD_WIDTH-1:0] child_centre_z
);

  // Width of the child centre sum: room for the coordinate or the half size, plus sign
  // and carry.
  localparam int HALF_W = SIZE_W - 1;
  localparam int SUM_W  = ((COORD_WIDTH > HALF_W) ? COORD_WIDTH : HALF_W) + 2;

  localparam logic signed [SUM_W-1:0] COORD_MAX =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COORD_MIN = ~COORD_MAX;

  typedef struct packed {
    logic [OCT_W-1:0]              octant;
    logic                          sampled;
    logic [COUNT_WIDTH-1:0]        octant_count;
    logic [COUNT_WIDTH-1:0]        sampled_total;
    logic signed [COORD_WIDTH-1:0] child_x;
    logic signed [COORD_WIDTH-1:0] child_y;
    logic signed [COORD_WIDTH-1:0] child_z;
  } res_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] centre_x;
  logic signed [COORD_WIDTH-1:0] centre_y;
  logic signed [COORD_WIDTH-1:0] centre_z;
  logic [SIZE_W-1:0]             node_size;
  logic [INTERVAL_W-1:0]         samp_period;

  logic     cfg_we;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x    <= '0;
      centre_y    <= '0;
      centre_z    <= '0;
      node_size   <= '0;
      samp_period <= INTERVAL_W'(1);
    end else if (cfg_we) begin
      // Indexes past the register list fall through and are dropped.
      case (cfg_idx)
        REG_CENTRE_X:    centre_x    <= pwdata[COORD_WIDTH-1:0];
        REG_CENTRE_Y:    centre_y    <= pwdata[COORD_WIDTH-1:0];
        REG_CENTRE_Z:    centre_z    <= pwdata[COORD_WIDTH-1:0];
        REG_NODE_SIZE:   node_size   <= pwdata[SIZE_W-1:0];
        REG_SAMP_PERIOD: samp_period <= pwdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back: centres sign-extended, the rest zero-extended.
  always_comb begin
    case (cfg_idx)
      REG_CENTRE_X:    prdata = DATA_W'(centre_x);
      REG_CENTRE_Y:    prdata = DATA_W'(centre_y);
      REG_CENTRE_Z:    prdata = DATA_W'(centre_z);
      REG_NODE_SIZE:   prdata = DATA_W'(node_size);
      REG_SAMP_PERIOD: prdata = DATA_W'(samp_period);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Running state
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] octant_counts [NUM_OCT];
  logic [INTERVAL_W-1:0]  sample_phase;
  logic [COUNT_WIDTH-1:0] sampled_count;

  logic                   in_accept;
  logic [OCT_W-1:0]       oct;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [INTERVAL_W-1:0]  phase_cur;
  logic [INTERVAL_W:0]    phase_inc;
  logic [INTERVAL_W-1:0]  interval_eff;
  logic [INTERVAL_W-1:0]  sample_phase_next;
  logic [COUNT_WIDTH-1:0] total_cur;
  logic [COUNT_WIDTH-1:0] sampled_count_next;
  logic                   smp;
  logic [HALF_W-1:0]      half;
  res_t                   res;

  assign in_accept = in_valid && in_ready;

  // Strict compare per axis: a point on the centre plane goes below.
  assign oct[OCT_X_BIT] = point_x > centre_x;
  assign oct[OCT_Y_BIT] = point_y > centre_y;
  assign oct[OCT_Z_BIT] = point_z > centre_z;

  // A start flag clears the counters, sample phase and sampled total ahead of this point.
  always_comb begin
    cnt_cur   = start_node ? '0 : octant_counts[oct];
    phase_cur = start_node ? '0 : sample_phase;
    total_cur = start_node ? '0 : sampled_count;
  end

  assign cnt_next     = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign smp          = (phase_cur == '0);
  assign sampled_count_next =
    (!smp || (&total_cur)) ? total_cur : total_cur + COUNT_WIDTH'(1);
  assign interval_eff = (samp_period == '0) ? INTERVAL_W'(1) : samp_period;
  assign phase_inc    = {1'b0, phase_cur} + (INTERVAL_W+1)'(1);
  // Wrap as soon as the advanced phase reaches the interval in force now.
  assign sample_phase_next =
    (phase_inc >= {1'b0, interval_eff}) ? '0 : phase_inc[INTERVAL_W-1:0];

  assign half = node_size[SIZE_W-1:1];

  function automatic logic signed [COORD_WIDTH-1:0] child_coord(
    input logic signed [COORD_WIDTH-1:0] c,
    input logic                          above,
    input logic [HALF_W-1:0]             h
  );
    logic signed [SUM_W-1:0] c_ext;
    logic signed [SUM_W-1:0] h_ext;
    logic signed [SUM_W-1:0] sum;
    c_ext = SUM_W'(c);
    h_ext = signed'({{(SUM_W-HALF_W){1'b0}}, h});
    sum   = above ? c_ext + h_ext : c_ext - h_ext;
    if (sum > COORD_MAX) begin
      return COORD_MAX[COORD_WIDTH-1:0];
    end else if (sum < COORD_MIN) begin
      return COORD_MIN[COORD_WIDTH-1:0];
    end
    return sum[COORD_WIDTH-1:0];
  endfunction

  always_comb begin
    res.octant        = oct;
    res.sampled       = smp;
    res.octant_count  = cnt_next;
    res.sampled_total = sampled_count_next;
    res.child_x       = child_coord(centre_x, oct[OCT_X_BIT], half);
    res.child_y       = child_coord(centre_y, oct[OCT_Y_BIT], half);
    res.child_z       = child_coord(centre_z, oct[OCT_Z_BIT], half);
  end

  // Commit state on accept; the start flag clears the other octants too.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OCT; i++) begin
        octant_counts[i] <= '0;
      end
      sample_phase  <= '0;
      sampled_count <= '0;
    end else if (in_accept) begin
      for (int i = 0; i < NUM_OCT; i++) begin
        if (OCT_W'(i) == oct) begin
          octant_counts[i] <= cnt_next;
        end else if (start_node) begin
          octant_counts[i] <= '0;
        end
      end
      sample_phase  <= sample_phase_next;
      sampled_count <= sampled_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: result register backed by a skid register
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic skid_valid;
  res_t out_res;
  res_t skid_res;
  logic out_pop;

  assign in_ready = !skid_valid;
  assign out_pop  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid) begin
        // Advance the waiting item; no new item is taken while the skid is full.
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (in_accept) begin
        out_res <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r) begin
        // Result register is held; park the new item.
        skid_res   <= res;
        skid_valid <= 1'b1;
      end else begin
        out_res     <= res;
        out_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign octant         = out_res.octant;
  assign sampled        = out_res.sampled;
  assign octant_count   = out_res.octant_count;
  assign sampled_total  = out_res.sampled_total;
  assign child_centre_x = out_res.child_x;
  assign child_centre_y = out_res.child_y;
  assign child_centre_z = out_res.child_z;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid_r)
    else $error("skid register holds an item while the result register is empty");

  a_sampled_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid_r && out_res.sampled) |-> (out_res.sampled_total != '0))
    else $error("sampled result carries a zero sampled total");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (out_valid_r && ((skid_valid ? skid_res.octant_count
                                               : out_res.octant_count) != '0)))
    else $error("accepted item did not land with a nonzero octant count");

endmodule
